// ----- rtl/core/rdr_pkg.sv -----
// Shared constants, types and the rotating layout table for degraded-row reassembly.
package rdr_pkg;

	localparam int DISKS       = 7;
	localparam int SLOTS       = 5;
	localparam int NUM_ROWS    = 7;
	localparam int WORD_W      = 64;
	localparam int BLOCK_WORDS = 8192;
	localparam int OFFSET_W    = 13;
	localparam int ROW_W       = 3;
	localparam int SLOT_W      = 3;
	localparam int IN_TDATA_W  = DISKS * WORD_W;
	localparam int OUT_FIELD_W = WORD_W + SLOT_W + ROW_W + OFFSET_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

	localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(SLOTS - 1);
	localparam logic [ROW_W-1:0]    LAST_ROW  = ROW_W'(NUM_ROWS - 1);
	localparam logic [OFFSET_W-1:0] LAST_WORD = OFFSET_W'(BLOCK_WORDS - 1);

	// Disk role: 0..4 is data block 1..5, then XOR parity, RS parity, ignored
	typedef enum logic [2:0] {
		TAG_B1   = 3'd0,
		TAG_B2   = 3'd1,
		TAG_B3   = 3'd2,
		TAG_B4   = 3'd3,
		TAG_B5   = 3'd4,
		TAG_XOR  = 3'd5,
		TAG_RS   = 3'd6,
		TAG_NONE = 3'd7
	} tag_t;

	typedef struct packed {
		logic [SLOTS-1:0][WORD_W-1:0] word;
		logic                         bad;
	} row_res_t;

	function automatic tag_t layout_tag(input logic [ROW_W-1:0] row, input int disk);
		tag_t r [DISKS];
		case (row)
			3'd0: r = '{TAG_XOR, TAG_RS, TAG_B1, TAG_B2, TAG_B3, TAG_B4, TAG_B5};
			3'd1: r = '{TAG_B1, TAG_XOR, TAG_RS, TAG_B2, TAG_B3, TAG_B4, TAG_B5};
			3'd2: r = '{TAG_B1, TAG_B2, TAG_XOR, TAG_RS, TAG_B3, TAG_B4, TAG_B5};
			3'd3: r = '{TAG_B1, TAG_B2, TAG_B3, TAG_XOR, TAG_NONE, TAG_B4, TAG_B5};
			3'd4: r = '{TAG_B1, TAG_B2, TAG_B3, TAG_B4, TAG_XOR, TAG_RS, TAG_B5};
			3'd5: r = '{TAG_B1, TAG_B2, TAG_B3, TAG_B4, TAG_B5, TAG_XOR, TAG_RS};
			3'd6: r = '{TAG_RS, TAG_B1, TAG_B2, TAG_B3, TAG_B4, TAG_B5, TAG_XOR};
			default: r = '{default: TAG_NONE};
		endcase
		return r[disk];
	endfunction

endpackage

// ----- rtl/core/rdr_decode.sv -----
// Row decode: sorts disk words into data slots and rebuilds a single lost slot by XOR.
module rdr_decode (
	input  logic [rdr_pkg::DISKS-1:0][rdr_pkg::WORD_W-1:0] disk_word,
	input  logic [rdr_pkg::ROW_W-1:0]                      row,
	input  logic [rdr_pkg::DISKS-1:0]                      missing_mask,
	output rdr_pkg::row_res_t                              res
);
	import rdr_pkg::*;

	tag_t                         tag [DISKS];
	logic [SLOTS-1:0][WORD_W-1:0] slot_word;
	logic [SLOTS-1:0]             slot_lost;
	logic [WORD_W-1:0]            acc;
	logic                         xor_present;
	logic [SLOT_W-1:0]            lost_count;
	logic                         bad;

	always_comb begin
		slot_word   = '0;
		slot_lost   = '0;
		acc         = '0;
		xor_present = 1'b0;
		for (int d = 0; d < DISKS; d++) begin
			tag[d] = layout_tag(row, d);
			for (int k = 0; k < SLOTS; k++) begin
				if (tag[d] == tag_t'(k)) begin
					if (missing_mask[d]) begin
						slot_lost[k] = 1'b1;
					end else begin
						slot_word[k] = disk_word[d];
					end
				end
			end
			if (!missing_mask[d] && (tag[d] <= TAG_B5 || tag[d] == TAG_XOR)) begin
				acc = acc ^ disk_word[d];
			end
			if (!missing_mask[d] && tag[d] == TAG_XOR) begin
				xor_present = 1'b1;
			end
		end
		lost_count = SLOT_W'($countones(slot_lost));
		bad = (lost_count >= SLOT_W'(2)) || (lost_count == SLOT_W'(1) && !xor_present);
		for (int k = 0; k < SLOTS; k++) begin
			res.word[k] = slot_lost[k] ? (bad ? '0 : acc) : slot_word[k];
		end
		res.bad = bad;
	end

endmodule

// ----- rtl/core/rdr_serial.sv -----
// Row buffer and output register: hands out a row's five slot words, one per cycle unless stalled.
module rdr_serial (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rdr_pkg::row_res_t                 res,
	input  logic [rdr_pkg::ROW_W-1:0]         row,
	input  logic [rdr_pkg::OFFSET_W-1:0]      offset,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rdr_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tlast,
	output logic                              m_tuser
);
	import rdr_pkg::*;

	row_res_t            res_s1;
	logic [ROW_W-1:0]    row_s1;
	logic [OFFSET_W-1:0] off_s1;
	logic                valid_s1;
	logic [SLOT_W-1:0]   slot_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   word_q;
	logic [SLOT_W-1:0]   slot_out_q;
	logic [ROW_W-1:0]    row_out_q;
	logic [OFFSET_W-1:0] off_out_q;
	logic                last_q;
	logic                bad_q;
	logic                out_adv;
	logic                take;
	logic                row_done;
	logic                accept;

	assign out_adv  = !out_valid_q || m_tready;
	assign take     = valid_s1 && out_adv;
	assign row_done = take && (slot_q == LAST_SLOT);
	assign in_ready = !valid_s1 || row_done;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (row_done) begin
				valid_s1 <= 1'b0;
			end
			if (take) begin
				slot_q <= row_done ? '0 : slot_q + SLOT_W'(1);
			end
			if (out_adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
			row_s1 <= row;
			off_s1 <= offset;
		end
		if (take) begin
			word_q     <= res_s1.word[slot_q];
			slot_out_q <= slot_q;
			row_out_q  <= row_s1;
			off_out_q  <= off_s1;
			last_q     <= (slot_q == LAST_SLOT);
			bad_q      <= res_s1.bad;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({off_out_q, row_out_q, slot_out_q, word_q});
	assign m_tlast  = last_q;
	assign m_tuser  = bad_q;

endmodule

// ----- rtl/core/raid_degraded_row_reassembly.sv -----
// Top level of the degraded-row reassembly block: counters, mask register, decode and output.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata: seven disk words
//  m_*       out  m_tvalid/m_tready  m_tdata, m_tlast (fifth word), m_tuser (unrecoverable)
//  mask cfg  in   missing_mask_we    missing_mask_wdata
//
// Each input item yields five result items, one per cycle unless the output stalls. The row
// buffer feeds the output register and takes the next item in the cycle that registers the
// fifth result of the last. Reset clears the mask, the word and row counters and all valid
// flags. A stalled output holds its item and the row buffer; s_tready drops if that is full.
module raid_degraded_row_reassembly (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// disk0_word, disk1_word, ..., disk6_word
	input  logic [rdr_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// data_word, slot_in_row, row_number, word_offset, zero fill
	output logic [rdr_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                m_tlast,
	// unrecoverable
	output logic                                m_tuser,
	input  logic                                missing_mask_we,
	input  logic [rdr_pkg::DISKS-1:0]           missing_mask_wdata
);
	import rdr_pkg::*;

	logic [DISKS-1:0]              mask_q;
	logic [OFFSET_W-1:0]           word_q;
	logic [ROW_W-1:0]              row_q;
	logic [DISKS-1:0][WORD_W-1:0]  disk_word;
	row_res_t                      res;
	logic                          accept;

	assign disk_word = s_tdata;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			word_q <= '0;
			row_q  <= '0;
		end else begin
			if (missing_mask_we) begin
				mask_q <= missing_mask_wdata;
			end
			if (accept) begin
				if (word_q == LAST_WORD) begin
					word_q <= '0;
					row_q  <= (row_q == LAST_ROW) ? '0 : row_q + ROW_W'(1);
				end else begin
					word_q <= word_q + OFFSET_W'(1);
				end
			end
		end
	end

	rdr_decode u_decode (
		.disk_word    (disk_word),
		.row          (row_q),
		.missing_mask (mask_q),
		.res          (res)
	);

	rdr_serial u_serial (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.res      (res),
		.row      (row_q),
		.offset   (word_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

`ifndef SYNTH
	a_last_on_fifth: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (m_tdata[WORD_W+SLOT_W-1:WORD_W] == LAST_SLOT)))
		else $error("tlast does not match the fifth slot");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[WORD_W+SLOT_W-1:WORD_W] <= LAST_SLOT))
		else $error("slot number out of range");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= LAST_ROW)
		else $error("row counter out of range");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && word_q != LAST_WORD) |=> $stable(row_q))
		else $error("row counter moved inside a block");
`endif

endmodule

// ----- tb/tb.sv -----
// Testbench for the degraded-row reassembly block: predicts the five data words per stripe.
module tb;
	import rdr_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam int HOLD_CYCLES = 300;

	typedef enum {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

	typedef struct packed {
		logic [WORD_W-1:0]   data_word;
		logic [SLOT_W-1:0]   slot;
		logic [ROW_W-1:0]    row;
		logic [OFFSET_W-1:0] offset;
		logic                last;
		logic                bad;
	} slot_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;
	logic                   missing_mask_we;
	logic [DISKS-1:0]       missing_mask_wdata;

	tag_t disk_roles [NUM_ROWS][DISKS] = '{
		'{TAG_XOR, TAG_RS, TAG_B1, TAG_B2, TAG_B3, TAG_B4, TAG_B5},
		'{TAG_B1, TAG_XOR, TAG_RS, TAG_B2, TAG_B3, TAG_B4, TAG_B5},
		'{TAG_B1, TAG_B2, TAG_XOR, TAG_RS, TAG_B3, TAG_B4, TAG_B5},
		'{TAG_B1, TAG_B2, TAG_B3, TAG_XOR, TAG_NONE, TAG_B4, TAG_B5},
		'{TAG_B1, TAG_B2, TAG_B3, TAG_B4, TAG_XOR, TAG_RS, TAG_B5},
		'{TAG_B1, TAG_B2, TAG_B3, TAG_B4, TAG_B5, TAG_XOR, TAG_RS},
		'{TAG_RS, TAG_B1, TAG_B2, TAG_B3, TAG_B4, TAG_B5, TAG_XOR}
	};

	slot_result_t        expected_slots [$];
	logic [DISKS-1:0]    mask_copy;
	logic [OFFSET_W-1:0] word_ctr;
	logic [ROW_W-1:0]    row_ctr;
	pace_t               pace;
	int                  hold_req;
	int                  hold_seen;
	int                  hold_left;
	int                  error_count;
	int                  cycle_count;

	raid_degraded_row_reassembly dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.s_tvalid           (s_tvalid),
		.s_tready           (s_tready),
		.s_tdata            (s_tdata),
		.m_tvalid           (m_tvalid),
		.m_tready           (m_tready),
		.m_tdata            (m_tdata),
		.m_tlast            (m_tlast),
		.m_tuser            (m_tuser),
		.missing_mask_we    (missing_mask_we),
		.missing_mask_wdata (missing_mask_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		error_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	function automatic int send_idle_pct(input pace_t p);
		case (p)
			PACE_SEND_GAPS: return 51;
			PACE_BOTH:      return 6;
			default:        return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(input pace_t p);
		case (p)
			PACE_RECV_STALLS: return 51;
			PACE_BOTH:        return 6;
			default:          return 0;
		endcase
	endfunction

	// receiver: random stalls, plus long hold-offs on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct(pace));
			end
		end
	end

	always @(posedge clk) begin : result_check
		slot_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_slots.size() == 0) begin
				flag_mismatch("result with nothing pending");
			end else begin
				want = expected_slots.pop_front();
				check_field("data_word", m_tdata[WORD_W-1:0], want.data_word);
				check_field("slot_in_row", 64'(m_tdata[WORD_W +: SLOT_W]),
					64'(want.slot));
				check_field("row_number", 64'(m_tdata[WORD_W+SLOT_W +: ROW_W]),
					64'(want.row));
				check_field("word_offset",
					64'(m_tdata[WORD_W+SLOT_W+ROW_W +: OFFSET_W]), 64'(want.offset));
				check_field("zero_fill", 64'(m_tdata[OUT_TDATA_W-1:OUT_FIELD_W]), '0);
				check_field("last_of_item", 64'(m_tlast), 64'(want.last));
				check_field("unrecoverable", 64'(m_tuser), 64'(want.bad));
			end
		end
	end

	task automatic predict_stripe(input logic [IN_TDATA_W-1:0] words);
		logic [WORD_W-1:0] slot_word [SLOTS];
		bit                slot_lost [SLOTS];
		logic [WORD_W-1:0] parity_acc;
		logic [WORD_W-1:0] w;
		int                lost_count;
		int                lost_slot;
		bit                xor_seen;
		bit                bad;
		tag_t              role;
		slot_result_t      r;
		parity_acc = '0;
		lost_count = 0;
		lost_slot = 0;
		xor_seen = 0;
		for (int k = 0; k < SLOTS; k++) begin
			slot_word[k] = '0;
			slot_lost[k] = 0;
		end
		for (int d = 0; d < DISKS; d++) begin
			role = disk_roles[row_ctr][d];
			w = words[d*WORD_W +: WORD_W];
			if (role <= TAG_B5) begin
				if (mask_copy[d]) begin
					slot_lost[int'(role)] = 1;
					lost_count++;
					lost_slot = int'(role);
				end else begin
					slot_word[int'(role)] = w;
					parity_acc ^= w;
				end
			end else if (role == TAG_XOR && !mask_copy[d]) begin
				xor_seen = 1;
				parity_acc ^= w;
			end
		end
		bad = (lost_count >= 2) || (lost_count == 1 && !xor_seen);
		if (lost_count == 1 && !bad)
			slot_word[lost_slot] = parity_acc;
		for (int k = 0; k < SLOTS; k++) begin
			r.data_word = (slot_lost[k] && bad) ? '0 : slot_word[k];
			r.slot = SLOT_W'(k);
			r.row = row_ctr;
			r.offset = word_ctr;
			r.last = (k == SLOTS - 1);
			r.bad = bad;
			expected_slots = {expected_slots, r};
		end
		if (word_ctr == LAST_WORD) begin
			word_ctr = '0;
			row_ctr = (row_ctr == LAST_ROW) ? '0 : row_ctr + 1'b1;
		end else begin
			word_ctr = word_ctr + 1'b1;
		end
	endtask

	// hold valid between back-to-back items; lower it only for a gap
	task automatic offer_stripe(input logic [IN_TDATA_W-1:0] words);
		int gap;
		gap = 0;
		while (gap < 20 && $urandom_range(99) < send_idle_pct(pace))
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= words;
		do @(posedge clk); while (!s_tready);
		predict_stripe(words);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_slots.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_missing_mask(input logic [DISKS-1:0] value);
		wait_idle();
		missing_mask_we <= 1'b1;
		missing_mask_wdata <= value;
		@(posedge clk);
		missing_mask_we <= 1'b0;
		mask_copy = value;
	endtask

	function automatic logic [WORD_W-1:0] random_word();
		case ($urandom_range(7))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [IN_TDATA_W-1:0] random_stripe();
		logic [IN_TDATA_W-1:0] s;
		for (int d = 0; d < DISKS; d++)
			s[d*WORD_W +: WORD_W] = random_word();
		return s;
	endfunction

	function automatic int random_data_disk(input logic [ROW_W-1:0] row);
		int d;
		d = $urandom_range(DISKS - 1);
		while (disk_roles[row][d] > TAG_B5)
			d = $urandom_range(DISKS - 1);
		return d;
	endfunction

	// mostly one lost data disk; sometimes parity-only, double loss or noise
	function automatic logic [DISKS-1:0] pick_mask(input logic [ROW_W-1:0] row);
		logic [DISKS-1:0] spare;
		logic [DISKS-1:0] m;
		int               xor_disk;
		int               first;
		int               second;
		spare = '0;
		xor_disk = 0;
		for (int d = 0; d < DISKS; d++) begin
			if (disk_roles[row][d] == TAG_XOR)
				xor_disk = d;
			else if (disk_roles[row][d] > TAG_B5)
				spare[d] = 1'b1;
		end
		m = DISKS'($urandom) & spare;
		first = random_data_disk(row);
		case ($urandom_range(9))
			0, 1, 2, 3, 4: m[first] = 1'b1;
			5: m[xor_disk] = 1'($urandom_range(1));
			6: begin
				m[xor_disk] = 1'b1;
				m[first] = 1'b1;
			end
			7: begin
				second = random_data_disk(row);
				while (second == first)
					second = random_data_disk(row);
				m[first] = 1'b1;
				m[second] = 1'b1;
			end
			8: m = DISKS'($urandom);
			default: m = $urandom_range(1) ? '1 : '0;
		endcase
		return m;
	endfunction

	function automatic logic [IN_TDATA_W-1:0] fill_stripe(input logic [WORD_W-1:0] w);
		return {DISKS{w}};
	endfunction

	task automatic test_directed();
		logic [IN_TDATA_W-1:0] s;
		pace <= PACE_FULL;
		set_missing_mask('0);
		offer_stripe(fill_stripe('0));
		offer_stripe(fill_stripe('1));
		offer_stripe(fill_stripe({16{4'h5}}));
		offer_stripe(fill_stripe({16{4'hA}}));
		for (int d = 0; d < DISKS; d++)
			s[d*WORD_W +: WORD_W] = {8{8'(d + 1)}};
		offer_stripe(s);
		offer_stripe(random_stripe());
		// first and last data slot lost, rebuilt from parity
		set_missing_mask(7'b0000100);
		offer_stripe(random_stripe());
		offer_stripe(fill_stripe('1));
		set_missing_mask(7'b1000000);
		offer_stripe(random_stripe());
		// parity disks alone missing
		set_missing_mask(7'b0000001);
		offer_stripe(random_stripe());
		set_missing_mask(7'b0000010);
		offer_stripe(random_stripe());
		// two data disks lost
		set_missing_mask(7'b0001100);
		offer_stripe(random_stripe());
		offer_stripe(fill_stripe('1));
		// data and XOR parity lost together
		set_missing_mask(7'b0010001);
		offer_stripe(fill_stripe('1));
		set_missing_mask('1);
		offer_stripe(fill_stripe('1));
		offer_stripe(random_stripe());
		set_missing_mask('0);
		offer_stripe(random_stripe());
	endtask

	task automatic test_random_traffic();
		pace_t phases [4];
		phases = '{PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH};
		for (int p = 0; p < 4; p++) begin
			for (int n = 0; n < 48; n++) begin
				if (n % 16 == 0) begin
					set_missing_mask(pick_mask(row_ctr));
					pace <= phases[p];
				end
				offer_stripe(random_stripe());
			end
		end
	endtask

	task automatic test_output_backpressure();
		set_missing_mask(pick_mask(row_ctr));
		pace <= PACE_FULL;
		hold_req <= hold_req + 1;
		for (int n = 0; n < 40; n++)
			offer_stripe(random_stripe());
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		missing_mask_we <= 1'b0;
		missing_mask_wdata <= '0;
		pace <= PACE_FULL;
		hold_req <= 0;
		hold_seen = 0;
		hold_left = 0;
		error_count = 0;
		cycle_count = 0;
		mask_copy = '0;
		word_ctr = '0;
		row_ctr = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic();
		test_output_backpressure();
		wait_idle();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
